// ===== rtl/core/ula_pkg.sv =====
// shared types and constants for the port decode and nmi generator
package ula_pkg;

   typedef enum logic [2:0] {
      FUNC_IO_READ   = 3'd0,
      FUNC_IO_WRITE  = 3'd1,
      FUNC_STEP      = 3'd2,
      FUNC_FETCH     = 3'd3,
      FUNC_MEM       = 3'd4,
      FUNC_KEY_SET   = 3'd5,
      FUNC_RSVD6     = 3'd6,
      FUNC_RSVD7     = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      TGT_ROM      = 2'd0,
      TGT_RAM      = 2'd1,
      TGT_UNMAPPED = 2'd2,
      TGT_RSVD     = 2'd3
   } mem_target_type;

   localparam logic [1:0] CSR_LINE_TSTATES  = 2'd0;
   localparam logic [1:0] CSR_RAM_SIZE_LOG2 = 2'd1;

   localparam logic [9:0]  LINE_TSTATES_RST  = 10'd207;
   localparam logic [3:0]  RAM_SIZE_LOG2_RST = 4'd14;
   localparam logic [3:0]  RAM_LOG2_MIN      = 4'd10;
   localparam logic [3:0]  RAM_LOG2_MAX      = 4'd14;
   localparam logic [7:0]  KEY_ROW_RST       = 8'hFF;
   localparam logic [7:0]  KEY_MASK          = 8'hBF;
   localparam logic [7:0]  EAR_BIT           = 8'h40;
   localparam logic [7:0]  OPCODE_NOP        = 8'h00;
   localparam logic [7:0]  READ_IDLE         = 8'hFF;
   localparam logic [13:0] ROM_MASK          = 14'h1FFF;
   localparam logic [15:0] ACC_MAX           = 16'hFFFF;

endpackage

// ===== rtl/core/ula_port_decode_and_nmi_generator_unit.sv =====
// top level: port decode, keyboard read, nmi line generator and memory decode
// an accepted item is held in the input register, then in the result register as valid
// one item per cycle unless the result stalls; accumulator and latches update in one pass
// input stall follows result stall in the same cycle once both registers hold items
// reset: synchronous, clears generator, accumulator, latches, keyboard rows to released
// and config registers to 207 t-states per line and 16k of ram
module ula_port_decode_and_nmi_generator_unit
   import ula_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   input  logic        req_is_write,
   input  logic [7:0]  req_tstate_delta,
   input  logic [7:0]  req_refresh_reg,
   input  logic        req_tape_active,
   input  logic        req_tape_level,
   input  logic [2:0]  req_key_row_index,
   input  logic [7:0]  req_key_row_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nmi_request,
   output logic        rsp_int_request,
   output logic        rsp_mic_level,
   output logic        rsp_ear_level,
   output logic [1:0]  rsp_mem_target,
   output logic [13:0] rsp_mem_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   // config registers
   logic [9:0] line_tstates_ff;
   logic [3:0] ram_size_log2_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   func_type    s1_func_ff;
   logic [15:0] s1_address_ff;
   logic [7:0]  s1_data_ff;
   logic        s1_is_write_ff;
   logic [7:0]  s1_delta_ff;
   logic [7:0]  s1_refresh_ff;
   logic        s1_tape_active_ff;
   logic        s1_tape_level_ff;
   logic [2:0]  s1_key_index_ff;
   logic [7:0]  s1_key_bits_ff;

   // block state
   logic        gen_on_ff, gen_on_in;
   logic [15:0] acc_ff, acc_in;
   logic        mic_ff, mic_in;
   logic        ear_ff, ear_in;
   logic [7:0]  key_rows_ff [8];

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rd_ff, rd_in;
   logic        nmi_ff, nmi_in;
   logic        irq_ff, irq_in;
   logic [1:0]  tgt_ff, tgt_in;
   logic [13:0] off_ff, off_in;

   logic        req_accept;
   logic        s1_adv;

   // decode helpers
   logic [3:0]  ram_lg;
   logic [13:0] ram_mask;
   logic [1:0]  dec_tgt;
   logic [13:0] dec_off;
   logic [7:0]  key_and;
   logic        ear_src;
   logic [16:0] acc_sum;
   logic [15:0] acc_sat;

   assign csr_ready  = 1'b1;
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_tstates_ff  <= LINE_TSTATES_RST;
         ram_size_log2_ff <= RAM_SIZE_LOG2_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_LINE_TSTATES) begin
            line_tstates_ff <= csr_wdata;
         end else if (csr_index == CSR_RAM_SIZE_LOG2) begin
            ram_size_log2_ff <= csr_wdata[3:0];
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff        <= func_type'(req_func);
         s1_address_ff     <= req_address;
         s1_data_ff        <= req_data;
         s1_is_write_ff    <= req_is_write;
         s1_delta_ff       <= req_tstate_delta;
         s1_refresh_ff     <= req_refresh_reg;
         s1_tape_active_ff <= req_tape_active;
         s1_tape_level_ff  <= req_tape_level;
         s1_key_index_ff   <= req_key_row_index;
         s1_key_bits_ff    <= req_key_row_bits;
      end
   end

   // memory decode
   always_comb begin
      ram_lg = ram_size_log2_ff;
      if (ram_lg < RAM_LOG2_MIN) begin
         ram_lg = RAM_LOG2_MIN;
      end else if (ram_lg > RAM_LOG2_MAX) begin
         ram_lg = RAM_LOG2_MAX;
      end
      ram_mask = 14'((15'd1 << ram_lg) - 15'd1);
      dec_tgt  = TGT_UNMAPPED;
      dec_off  = '0;
      unique case (s1_address_ff[15:14])
         2'b00, 2'b10: begin
            if (!(s1_is_write_ff && s1_func_ff == FUNC_MEM)) begin
               dec_tgt = TGT_ROM;
               dec_off = s1_address_ff[13:0] & ROM_MASK;
            end
         end
         2'b01: begin
            if ((s1_address_ff[13:0] & ~ram_mask) == 14'd0) begin
               dec_tgt = TGT_RAM;
               dec_off = s1_address_ff[13:0];
            end
         end
         2'b11: begin
            dec_tgt = TGT_RAM;
            dec_off = s1_address_ff[13:0] & ram_mask;
         end
         default: begin
            dec_tgt = TGT_UNMAPPED;
         end
      endcase
   end

   // keyboard rows selected low in the upper address byte
   always_comb begin
      key_and = KEY_MASK;
      for (int i = 0; i < 8; i++) begin
         if (!s1_address_ff[8 + i]) begin
            key_and = key_and & key_rows_ff[i];
         end
      end
      ear_src = s1_tape_active_ff ? s1_tape_level_ff : ear_ff;
   end

   // line accumulator with saturation
   always_comb begin
      acc_sum = {1'b0, acc_ff} + {9'd0, s1_delta_ff};
      acc_sat = acc_sum[16] ? ACC_MAX : acc_sum[15:0];
   end

   always_comb begin
      gen_on_in = gen_on_ff;
      acc_in    = acc_ff;
      mic_in    = mic_ff;
      ear_in    = ear_ff;
      rd_in     = READ_IDLE;
      nmi_in    = 1'b0;
      irq_in    = 1'b0;
      tgt_in    = TGT_UNMAPPED;
      off_in    = '0;
      unique case (s1_func_ff)
         FUNC_IO_READ: begin
            if (!s1_address_ff[0]) begin
               rd_in = (key_and & KEY_MASK) | (ear_src ? 8'h00 : EAR_BIT);
            end
         end
         FUNC_IO_WRITE: begin
            if (!s1_address_ff[0]) begin
               gen_on_in = 1'b0;
               mic_in    = s1_data_ff[3];
               ear_in    = s1_data_ff[4];
            end
            if (!s1_address_ff[1]) begin
               gen_on_in = 1'b1;
               acc_in    = '0;
            end
         end
         FUNC_STEP: begin
            if (gen_on_ff) begin
               if (acc_sat >= {6'd0, line_tstates_ff}) begin
                  acc_in = acc_sat - {6'd0, line_tstates_ff};
                  nmi_in = 1'b1;
               end else begin
                  acc_in = acc_sat;
               end
            end
            irq_in = !s1_refresh_ff[6];
         end
         FUNC_FETCH: begin
            tgt_in = dec_tgt;
            off_in = dec_off;
            rd_in  = (s1_address_ff[15] && !s1_data_ff[6]) ? OPCODE_NOP : s1_data_ff;
         end
         FUNC_MEM: begin
            tgt_in = dec_tgt;
            off_in = dec_off;
         end
         FUNC_KEY_SET, FUNC_RSVD6, FUNC_RSVD7: begin
            rd_in = READ_IDLE;
         end
         default: begin
            rd_in = READ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_on_ff <= 1'b0;
         acc_ff    <= '0;
         mic_ff    <= 1'b0;
         ear_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            key_rows_ff[i] <= KEY_ROW_RST;
         end
      end else if (s1_adv) begin
         gen_on_ff <= gen_on_in;
         acc_ff    <= acc_in;
         mic_ff    <= mic_in;
         ear_ff    <= ear_in;
         if (s1_func_ff == FUNC_KEY_SET) begin
            key_rows_ff[s1_key_index_ff] <= s1_key_bits_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rd_ff  <= rd_in;
         nmi_ff <= nmi_in;
         irq_ff <= irq_in;
         tgt_ff <= tgt_in;
         off_ff <= off_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rd_ff;
   assign rsp_nmi_request = nmi_ff;
   assign rsp_int_request = irq_ff;
   assign rsp_mic_level   = mic_ff;
   assign rsp_ear_level   = ear_ff;
   assign rsp_mem_target  = tgt_ff;
   assign rsp_mem_offset  = off_ff;

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty input register");

   a_nmi_only_from_step: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_func_ff != FUNC_STEP) |=> (!rsp_nmi_request && !rsp_int_request))
      else $error("interrupt request from a non-step item");

   a_target_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mem_target != TGT_RSVD))
      else $error("illegal memory target");

   a_unmapped_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mem_target == TGT_UNMAPPED) |-> (rsp_mem_offset == 14'd0))
      else $error("unmapped result with nonzero offset");

   a_state_holds_without_item: assert property (@(posedge clock) disable iff (reset)
      (!s1_adv && !$past(reset)) |=> ($stable(acc_ff) && $stable(gen_on_ff)))
      else $error("generator state moved without an item");

endmodule

// ===== sim/testbench.sv =====
// testbench for the port decode, keyboard read, nmi generator and memory decode unit
`timescale 1ns / 1ps

module testbench;
   import ula_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   typedef struct {
      func_type    func;
      logic [15:0] address;
      logic [7:0]  data;
      logic        is_write;
      logic [7:0]  tstate_delta;
      logic [7:0]  refresh_reg;
      logic        tape_active;
      logic        tape_level;
      logic [2:0]  key_row_index;
      logic [7:0]  key_row_bits;
   } bus_item_type;

   typedef struct {
      logic [7:0]     read_data;
      logic           nmi_request;
      logic           int_request;
      logic           mic_level;
      logic           ear_level;
      mem_target_type mem_target;
      logic [13:0]    mem_offset;
   } glue_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_data = '0;
   logic        req_is_write = 1'b0;
   logic [7:0]  req_tstate_delta = '0;
   logic [7:0]  req_refresh_reg = '0;
   logic        req_tape_active = 1'b0;
   logic        req_tape_level = 1'b0;
   logic [2:0]  req_key_row_index = '0;
   logic [7:0]  req_key_row_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_nmi_request;
   logic        rsp_int_request;
   logic        rsp_mic_level;
   logic        rsp_ear_level;
   logic [1:0]  rsp_mem_target;
   logic [13:0] rsp_mem_offset;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [9:0]  csr_wdata = '0;

   ula_port_decode_and_nmi_generator_unit u_dut (.*);

   // predictor state
   logic [9:0]  line_len;
   logic [3:0]  ram_log2;
   logic        gen_on;
   logic [15:0] line_acc;
   logic        mic_latch;
   logic        ear_latch;
   logic [7:0]  key_row_state [8];

   glue_result_type expected_q [$];

   int  errors = 0;
   int  items_sent = 0;
   int  csr_writes = 0;
   int  nmi_seen = 0;
   int  int_seen = 0;
   int  cycle_count = 0;
   bit  sender_idle = 1'b0;
   bit  receiver_idle = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_q.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic void map_memory(input logic [15:0] a, input logic wr,
                                      output mem_target_type tgt, output logic [13:0] off);
      logic [3:0]  lg;
      logic [15:0] ram_bytes;
      logic [15:0] o;
      lg = ram_log2;
      if (lg < RAM_LOG2_MIN) lg = RAM_LOG2_MIN;
      if (lg > RAM_LOG2_MAX) lg = RAM_LOG2_MAX;
      ram_bytes = 16'd1 << lg;
      tgt = TGT_UNMAPPED;
      off = '0;
      if (a < 16'h4000 || (a >= 16'h8000 && a < 16'hC000)) begin
         if (!wr) begin
            tgt = TGT_ROM;
            off = a[13:0] & ROM_MASK;
         end
      end else if (a < 16'h8000) begin
         o = a - 16'h4000;
         if (o < ram_bytes) begin
            tgt = TGT_RAM;
            off = o[13:0];
         end
      end else begin
         o = (a - 16'hC000) & (ram_bytes - 16'd1);
         tgt = TGT_RAM;
         off = o[13:0];
      end
   endfunction

   function automatic glue_result_type predict_glue(input bus_item_type it);
      glue_result_type r;
      logic [7:0]   rows;
      logic         ear;
      logic [16:0]  sum;
      int           i;
      r.read_data = READ_IDLE;
      r.nmi_request = 1'b0;
      r.int_request = 1'b0;
      r.mem_target = TGT_UNMAPPED;
      r.mem_offset = '0;
      case (it.func)
         FUNC_IO_READ: begin
            if (!it.address[0]) begin
               rows = KEY_MASK;
               for (i = 0; i < 8; i++)
                  if (!it.address[8 + i]) rows &= key_row_state[i];
               ear = it.tape_active ? it.tape_level : ear_latch;
               r.read_data = (rows & KEY_MASK) | (ear ? 8'h00 : EAR_BIT);
            end
         end
         FUNC_IO_WRITE: begin
            if (!it.address[0]) begin
               gen_on = 1'b0;
               mic_latch = it.data[3];
               ear_latch = it.data[4];
            end
            if (!it.address[1]) begin
               gen_on = 1'b1;
               line_acc = '0;
            end
         end
         FUNC_STEP: begin
            if (gen_on) begin
               sum = {1'b0, line_acc} + {9'd0, it.tstate_delta};
               if (sum > {1'b0, ACC_MAX}) sum = {1'b0, ACC_MAX};
               if (sum >= {7'd0, line_len}) begin
                  sum = sum - {7'd0, line_len};
                  r.nmi_request = 1'b1;
               end
               line_acc = sum[15:0];
            end
            r.int_request = !it.refresh_reg[6];
         end
         FUNC_FETCH: begin
            map_memory(it.address, 1'b0, r.mem_target, r.mem_offset);
            r.read_data = (it.address[15] && !it.data[6]) ? OPCODE_NOP : it.data;
         end
         FUNC_MEM: map_memory(it.address, it.is_write, r.mem_target, r.mem_offset);
         FUNC_KEY_SET: key_row_state[it.key_row_index] = it.key_row_bits;
         default: ;
      endcase
      r.mic_level = mic_latch;
      r.ear_level = ear_latch;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val,
                  act_val);
      end
   endtask

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      glue_result_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with no item outstanding, read_data 0x%0h", $time,
                     rsp_read_data);
         end else begin
            exp = expected_q.pop_front();
            check_field("read_data", exp.read_data, rsp_read_data);
            check_field("nmi_request", exp.nmi_request, rsp_nmi_request);
            check_field("int_request", exp.int_request, rsp_int_request);
            check_field("mic_level", exp.mic_level, rsp_mic_level);
            check_field("ear_level", exp.ear_level, rsp_ear_level);
            check_field("mem_target", exp.mem_target, rsp_mem_target);
            check_field("mem_offset", exp.mem_offset, rsp_mem_offset);
            if (rsp_nmi_request) nmi_seen++;
            if (rsp_int_request) int_seen++;
         end
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input bus_item_type it);
      if (sender_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_address <= it.address;
      req_data <= it.data;
      req_is_write <= it.is_write;
      req_tstate_delta <= it.tstate_delta;
      req_refresh_reg <= it.refresh_reg;
      req_tape_active <= it.tape_active;
      req_tape_level <= it.tape_level;
      req_key_row_index <= it.key_row_index;
      req_key_row_bits <= it.key_row_bits;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(predict_glue(it));
      items_sent++;
   endtask

   function automatic bus_item_type random_item(input func_type f);
      bus_item_type it;
      it.func = f;
      it.address = 16'($urandom);
      it.data = 8'($urandom);
      it.is_write = 1'($urandom);
      it.tstate_delta = 8'($urandom);
      it.refresh_reg = 8'($urandom);
      it.tape_active = 1'($urandom);
      it.tape_level = 1'($urandom);
      it.key_row_index = 3'($urandom);
      it.key_row_bits = 8'($urandom);
      return it;
   endfunction

   function automatic func_type pick_func();
      int w;
      w = $urandom_range(0, 99);
      if (w < 15) return FUNC_IO_READ;
      if (w < 25) return FUNC_IO_WRITE;
      if (w < 55) return FUNC_STEP;
      if (w < 65) return FUNC_FETCH;
      if (w < 85) return FUNC_MEM;
      if (w < 95) return FUNC_KEY_SET;
      return (w < 97) ? FUNC_RSVD6 : FUNC_RSVD7;
   endfunction

   // extra carries tape bits for port reads, refresh for steps, direction for memory
   task automatic send_op(input func_type f, input logic [15:0] a, input logic [7:0] d,
                          input logic [7:0] extra);
      bus_item_type it;
      it = random_item(f);
      it.address = a;
      it.data = d;
      case (f)
         FUNC_IO_READ: begin
            it.tape_active = extra[1];
            it.tape_level = extra[0];
         end
         FUNC_STEP: begin
            it.tstate_delta = d;
            it.refresh_reg = extra;
         end
         FUNC_MEM: it.is_write = extra[0];
         FUNC_KEY_SET: begin
            it.key_row_index = a[2:0];
            it.key_row_bits = d;
         end
         default: ;
      endcase
      send_item(it);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_item(random_item(pick_func()));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [9:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_LINE_TSTATES) line_len = value;
      else if (idx == CSR_RAM_SIZE_LOG2) ram_log2 = value[3:0];
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(FUNC_IO_READ, 16'hFEFE, 8'h00, 8'h00);
      send_op(FUNC_KEY_SET, 16'h0000, 8'h1E, 8'h00);
      send_op(FUNC_KEY_SET, 16'h0007, 8'hA5, 8'h00);
      send_op(FUNC_IO_READ, 16'h00FE, 8'h00, 8'h03);
      send_op(FUNC_IO_READ, 16'hFFFF, 8'h00, 8'h00);
      send_op(FUNC_IO_WRITE, 16'hFFFE, 8'h18, 8'h00);
      send_op(FUNC_IO_READ, 16'h7FFE, 8'h00, 8'h02);
      send_op(FUNC_IO_WRITE, 16'hFFFD, 8'hFF, 8'h00);
      send_op(FUNC_STEP, 16'h0000, 8'hFF, 8'h00);
      send_op(FUNC_STEP, 16'h0000, 8'h00, 8'h40);
      send_op(FUNC_STEP, 16'h0000, 8'hFF, 8'hBF);
      send_op(FUNC_IO_WRITE, 16'h0000, 8'h00, 8'h00);
      send_op(FUNC_IO_WRITE, 16'hFFFF, 8'hE7, 8'h00);
      send_op(FUNC_FETCH, 16'h8000, 8'h3F, 8'h00);
      send_op(FUNC_FETCH, 16'hFFFF, 8'hFF, 8'h00);
      send_op(FUNC_FETCH, 16'h7FFF, 8'h00, 8'h00);
      send_op(FUNC_MEM, 16'h0000, 8'h00, 8'h00);
      send_op(FUNC_MEM, 16'h3FFF, 8'h00, 8'h00);
      send_op(FUNC_MEM, 16'h3FFF, 8'h00, 8'h01);
      send_op(FUNC_MEM, 16'h4000, 8'h00, 8'h00);
      send_op(FUNC_MEM, 16'h7FFF, 8'h00, 8'h01);
      send_op(FUNC_MEM, 16'hBFFF, 8'h00, 8'h00);
      send_op(FUNC_MEM, 16'hC000, 8'h00, 8'h01);
      send_op(FUNC_MEM, 16'hFFFF, 8'h00, 8'h00);
      send_op(FUNC_RSVD6, 16'hFFFC, 8'hFF, 8'h00);
      send_op(FUNC_RSVD7, 16'h0000, 8'h00, 8'h00);
      wait_drained();
   endtask

   task automatic test_config_sweep();
      logic [9:0] lines [8] = '{10'd1, 10'd1023, 10'd0, 10'd100, 10'd207, 10'd512,
                                10'd3, 10'd1023};
      logic [9:0] ram_logs [8] = '{10'd10, 10'd14, 10'd15, 10'd9, 10'd11, 10'd12,
                                   10'd13, 10'd0};
      int k;
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      for (k = 0; k < 8; k++) begin
         write_csr(CSR_LINE_TSTATES, lines[k]);
         write_csr(CSR_RAM_SIZE_LOG2, ram_logs[k]);
         send_op(FUNC_IO_WRITE, 16'hFFFD, 8'h00, 8'h00);
         send_random(7);
      end
      wait_drained();
   endtask

   task automatic test_accumulator_saturation();
      write_csr(CSR_LINE_TSTATES, 10'd0);
      send_op(FUNC_IO_WRITE, 16'hFFFD, 8'h00, 8'h00);
      repeat (262) send_op(FUNC_STEP, 16'h0000, 8'hFF, 8'($urandom));
      send_op(FUNC_IO_WRITE, 16'hFFFC, 8'h08, 8'h00);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      write_csr(CSR_LINE_TSTATES, 10'($urandom_range(1, 1023)));
      write_csr(CSR_RAM_SIZE_LOG2, 10'($urandom_range(10, 14)));
      send_random(20);
      receiver_idle = 1'b0;
      sender_idle = 1'b0;
      send_random(10);
      receiver_idle = 1'b1;
      sender_idle = 1'b1;
      send_random(20);
      wait_drained();
   endtask

   task automatic test_backpressure();
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      hold_request = 1'b1;
      send_random(30);
      wait_drained();
   endtask

   task automatic test_quiet_tail();
      write_csr(CSR_LINE_TSTATES, LINE_TSTATES_RST);
      write_csr(CSR_RAM_SIZE_LOG2, 10'(RAM_SIZE_LOG2_RST));
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      send_random(30);
      wait_drained();
   endtask

   initial begin
      line_len = LINE_TSTATES_RST;
      ram_log2 = RAM_SIZE_LOG2_RST;
      gen_on = 1'b0;
      line_acc = '0;
      mic_latch = 1'b0;
      ear_latch = 1'b0;
      for (int i = 0; i < 8; i++) key_row_state[i] = KEY_ROW_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_accumulator_saturation();
      test_random_traffic();
      test_backpressure();
      test_quiet_tail();
      $display("checked %0d items under %0d register writes across line lengths and ram sizes",
               items_sent, csr_writes);
      $display("saw %0d nmi and %0d int requests, %0d mismatches", nmi_seen, int_seen,
               errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ula_pkg.sv
rtl/core/ula_port_decode_and_nmi_generator_unit.sv
sim/testbench.sv
